### design/sat_pkg.sv
// ----------------------------------------------------------------------------
// sat_pkg
// Types and codes shared by the associative table top level and its cells.
// ----------------------------------------------------------------------------
package sat_pkg;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned ValW   = 32;
  localparam int unsigned PosW   = 4;
  localparam int unsigned OutCntW = 5;

  typedef enum logic [1:0] {
    KIND_PUT    = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_READ   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NOT_FOUND    = 2'd1,
    ST_FULL         = 2'd2,
    ST_BAD_POSITION = 2'd3
  } status_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_e;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic              capture;
    logic [KeyW-1:0]   cap_key;
    logic              commit;
    kind_e             kind;
    logic [KeyW-1:0]   key;
    logic [ValW-1:0]   value;
    logic [PosW-1:0]   position;
    logic              put_new;
  } cell_ctl_t;

  // Accumulated along the row, one contribution per cell.
  typedef struct packed {
    logic              hit;
    logic [ValW-1:0]   hit_value;
    logic [KeyW-1:0]   tail_key;
    logic [ValW-1:0]   tail_value;
    logic              rd_hit;
    logic [KeyW-1:0]   rd_key;
    logic [ValW-1:0]   rd_value;
  } chain_t;

endpackage

### design/small_associative_table_unit.sv
// ----------------------------------------------------------------------------
// small_associative_table_unit
// Fixed-capacity key/value table kept densely in slots 0..count-1, built as a
// row of slot cells. Supports put, lookup, remove and read by position.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake              | Payload
//  --------+------------------------+-----------------------------------------
//  in      | in_valid_i / in_ready_o| kind_i, key_i, value_i, position_i
//  out     | out_valid_o/out_ready_i| status_o, found_o, key_out_o,
//          |                        | value_out_o, entry_count_o
//
// Each item is handled in order: at acceptance every cell compares its key with
// key_i and registers a hit flag; in the execute state the hit, tail and read
// contributions are merged along the cell row, the result is registered and
// the cells and count are updated. One item is in flight at a time.
// While an earlier result is not taken, the execute state holds.
// Reset clears the entry count and control state; slot contents are not reset.
// ----------------------------------------------------------------------------
module small_associative_table_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [31:0] key_i,
  input  logic [31:0] value_i,
  input  logic [3:0]  position_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic        found_o,
  output logic [31:0] key_out_o,
  output logic [31:0] value_out_o,
  output logic [4:0]  entry_count_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  sat_pkg::fsm_e state_q, state_d;

  // Command held from acceptance until the item commits.
  sat_pkg::kind_e              kind_q;
  logic [sat_pkg::KeyW-1:0]    key_q;
  logic [sat_pkg::ValW-1:0]    value_q;
  logic [sat_pkg::PosW-1:0]    position_q;

  logic [CntW-1:0]             count_q, count_d;

  logic                        out_valid_q, out_valid_d;
  sat_pkg::status_e            status_q, status_d;
  logic                        found_q, found_d;
  logic [31:0]                 key_out_q, key_out_d;
  logic [31:0]                 value_out_q, value_out_d;
  logic [4:0]                  entry_count_q, entry_count_d;

  logic                        accept, commit, full;
  sat_pkg::cell_ctl_t          ctl;
  sat_pkg::chain_t             chain [CAPACITY+1];
  sat_pkg::chain_t             total;

  assign accept = in_valid_i && in_ready_o;
  assign commit = (state_q == sat_pkg::FSM_EXEC) && (!out_valid_q || out_ready_i);
  assign full   = 32'(count_q) >= 32'(CAPACITY);
  assign total  = chain[CAPACITY];

  // ---------------------------------------------------------------- FSM
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sat_pkg::FSM_IDLE: if (in_valid_i) state_d = sat_pkg::FSM_EXEC;
      sat_pkg::FSM_EXEC: if (commit) state_d = sat_pkg::FSM_IDLE;
      default:           state_d = sat_pkg::FSM_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == sat_pkg::FSM_IDLE);
  end

  // ---------------------------------------------------------------- cell row
  always_comb begin
    ctl.capture  = accept;
    ctl.cap_key  = key_i;
    ctl.commit   = commit;
    ctl.kind     = kind_q;
    ctl.key      = key_q;
    ctl.value    = value_q;
    ctl.position = position_q;
    ctl.put_new  = !total.hit && !full;
  end

  assign chain[0] = '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    sat_cell #(
      .Idx  (g),
      .CntW (CntW)
    ) u_cell (
      .clk_i   (clk_i),
      .count_i (count_q),
      .ctl_i   (ctl),
      .chain_i (chain[g]),
      .total_i (total),
      .chain_o (chain[g+1])
    );
  end

  // ---------------------------------------------------------------- result
  always_comb begin
    count_d       = count_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    status_d      = status_q;
    found_d       = found_q;
    key_out_d     = key_out_q;
    value_out_d   = value_out_q;
    entry_count_d = entry_count_q;
    if (commit) begin
      out_valid_d = 1'b1;
      status_d    = sat_pkg::ST_OK;
      found_d     = 1'b0;
      key_out_d   = '0;
      value_out_d = '0;
      unique case (kind_q)
        sat_pkg::KIND_PUT: begin
          if (total.hit) begin
            found_d = 1'b1;
          end else if (full) begin
            status_d = sat_pkg::ST_FULL;
          end else begin
            count_d = count_q + CntW'(1);
          end
        end
        sat_pkg::KIND_LOOKUP: begin
          if (total.hit) begin
            found_d     = 1'b1;
            value_out_d = total.hit_value;
          end else begin
            status_d = sat_pkg::ST_NOT_FOUND;
          end
        end
        sat_pkg::KIND_REMOVE: begin
          // A hit implies at least one entry.
          if (total.hit) begin
            found_d     = 1'b1;
            value_out_d = total.hit_value;
            count_d     = count_q - CntW'(1);
          end else begin
            status_d = sat_pkg::ST_NOT_FOUND;
          end
        end
        sat_pkg::KIND_READ: begin
          if (total.rd_hit) begin
            key_out_d   = total.rd_key;
            value_out_d = total.rd_value;
          end else begin
            status_d = sat_pkg::ST_BAD_POSITION;
          end
        end
        default: begin
        end
      endcase
      entry_count_d = 5'(count_d);
    end
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sat_pkg::FSM_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Latch the command on acceptance; hold the result until taken.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q     <= sat_pkg::kind_e'(kind_i);
      key_q      <= key_i;
      value_q    <= value_i;
      position_q <= position_i;
    end
    status_q      <= status_d;
    found_q       <= found_d;
    key_out_q     <= key_out_d;
    value_out_q   <= value_out_d;
    entry_count_q <= entry_count_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign found_o       = found_q;
  assign key_out_o     = key_out_q;
  assign value_out_o   = value_out_q;
  assign entry_count_o = entry_count_q;

endmodule

### design/sat_cell.sv
// ----------------------------------------------------------------------------
// sat_cell
// One table slot: holds a key and value, compares against the search key and
// merges its contribution into the chain passed on to the next slot.
// ----------------------------------------------------------------------------
module sat_cell #(
  parameter int unsigned Idx  = 0,
  parameter int unsigned CntW = 5
) (
  input  logic               clk_i,
  input  logic [CntW-1:0]    count_i,
  input  sat_pkg::cell_ctl_t ctl_i,
  input  sat_pkg::chain_t    chain_i,
  input  sat_pkg::chain_t    total_i,
  output sat_pkg::chain_t    chain_o
);

  logic [sat_pkg::KeyW-1:0] key_q, key_d;
  logic [sat_pkg::ValW-1:0] value_q, value_d;
  logic                     hit_q, hit_d;
  logic                     occ, is_tail, is_next, rd_sel;

  assign occ     = 32'(Idx) < 32'(count_i);
  assign is_tail = (32'(Idx) + 32'd1) == 32'(count_i);
  assign is_next = 32'(Idx) == 32'(count_i);
  assign rd_sel  = occ && (32'(ctl_i.position) == 32'(Idx));

  // Merge own contribution into the row.
  always_comb begin
    chain_o            = chain_i;
    chain_o.hit        = chain_i.hit | hit_q;
    chain_o.hit_value  = chain_i.hit_value | (hit_q ? value_q : '0);
    chain_o.tail_key   = chain_i.tail_key | (is_tail ? key_q : '0);
    chain_o.tail_value = chain_i.tail_value | (is_tail ? value_q : '0);
    chain_o.rd_hit     = chain_i.rd_hit | rd_sel;
    chain_o.rd_key     = chain_i.rd_key | (rd_sel ? key_q : '0);
    chain_o.rd_value   = chain_i.rd_value | (rd_sel ? value_q : '0);
  end

  always_comb begin
    hit_d   = hit_q;
    key_d   = key_q;
    value_d = value_q;
    if (ctl_i.capture) begin
      hit_d = occ && (key_q == ctl_i.cap_key);
    end
    if (ctl_i.commit) begin
      unique case (ctl_i.kind)
        sat_pkg::KIND_PUT: begin
          if (hit_q) begin
            value_d = ctl_i.value;
          end else if (ctl_i.put_new && is_next) begin
            key_d   = ctl_i.key;
            value_d = ctl_i.value;
          end
        end
        sat_pkg::KIND_REMOVE: begin
          // Fill the freed slot from the tail entry.
          if (hit_q) begin
            key_d   = total_i.tail_key;
            value_d = total_i.tail_value;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q   <= hit_d;
    key_q   <= key_d;
    value_q <= value_d;
  end

endmodule

### tb/small_associative_table_unit_tb.sv
// ----------------------------------------------------------------------------
// small_associative_table_unit_tb
// Drives put, lookup, remove and read items into the associative table under
// random sender bursts and receiver stalls. A shadow copy of the table
// predicts every reply, which is checked field by field in order.
// ----------------------------------------------------------------------------
module small_associative_table_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Cap           = 16;
  localparam int unsigned PoolSize      = 20;
  localparam int unsigned RandomItems   = 1600;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned DrainCycles   = 4;

  // Expected reply for one item.
  typedef struct {
    sat_pkg::status_e status;
    logic             found;
    logic [31:0]      key_out;
    logic [31:0]      value_out;
    logic [4:0]       entry_count;
  } reply_t;

  // Shadow table plus the queue of replies still owed by the block.
  class table_checker;
    logic [31:0] slot_key[Cap];
    logic [31:0] slot_val[Cap];
    int unsigned fill;
    reply_t      awaited[$];
    int          n_errors;

    function new();
      fill     = 0;
      n_errors = 0;
    endfunction

    function int find_key(logic [31:0] k);
      for (int i = 0; i < fill; i++) begin
        if (slot_key[i] == k) return i;
      end
      return -1;
    endfunction

    // Apply one accepted item to the shadow table and queue its reply.
    function void note_request(sat_pkg::kind_e kind, logic [31:0] key,
                               logic [31:0] value, logic [3:0] position);
      reply_t r;
      int     slot;
      r.status    = sat_pkg::ST_OK;
      r.found     = 1'b0;
      r.key_out   = '0;
      r.value_out = '0;
      slot        = find_key(key);
      case (kind)
        sat_pkg::KIND_PUT: begin
          if (slot >= 0) begin
            slot_val[slot] = value;
            r.found        = 1'b1;
          end else if (fill >= Cap) begin
            r.status = sat_pkg::ST_FULL;
          end else begin
            slot_key[fill] = key;
            slot_val[fill] = value;
            fill++;
          end
        end
        sat_pkg::KIND_LOOKUP: begin
          if (slot >= 0) begin
            r.found     = 1'b1;
            r.value_out = slot_val[slot];
          end else begin
            r.status = sat_pkg::ST_NOT_FOUND;
          end
        end
        sat_pkg::KIND_REMOVE: begin
          if (slot >= 0) begin
            r.found     = 1'b1;
            r.value_out = slot_val[slot];
            fill--;
            // Move the last entry into the freed slot.
            slot_key[slot] = slot_key[fill];
            slot_val[slot] = slot_val[fill];
          end else begin
            r.status = sat_pkg::ST_NOT_FOUND;
          end
        end
        default: begin
          if (position < fill) begin
            r.key_out   = slot_key[position];
            r.value_out = slot_val[position];
          end else begin
            r.status = sat_pkg::ST_BAD_POSITION;
          end
        end
      endcase
      r.entry_count = 5'(fill);
      awaited.push_back(r);
    endfunction

    function void compare(string field, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s mismatch: expected %0h, actual %0h", field, exp_v, act_v);
        n_errors++;
      end
    endfunction

    // Check one reply taken from the block against the oldest expectation.
    function void check_reply(logic [1:0] status, logic found, logic [31:0] key_out,
                              logic [31:0] value_out, logic [4:0] entry_count);
      reply_t r;
      if (awaited.size() == 0) begin
        $error("reply with no item outstanding: status %0h", status);
        n_errors++;
        return;
      end
      r = awaited.pop_front();
      compare("status", 32'(r.status), 32'(status));
      compare("found", 32'(r.found), 32'(found));
      compare("key_out", r.key_out, key_out);
      compare("value_out", r.value_out, value_out);
      compare("entry_count", 32'(r.entry_count), 32'(entry_count));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [1:0]  kind_i       = '0;
  logic [31:0] key_i        = '0;
  logic [31:0] value_i      = '0;
  logic [3:0]  position_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic [1:0]  status_o;
  logic        found_o;
  logic [31:0] key_out_o;
  logic [31:0] value_out_o;
  logic [4:0]  entry_count_o;

  table_checker sb;
  int unsigned  quiet_cycles = 0;
  int           burst_left   = 0;
  logic [31:0]  key_pool[PoolSize];

  small_associative_table_unit #(
    .CAPACITY(Cap)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .key_i        (key_i),
    .value_i      (value_i),
    .position_i   (position_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .found_o      (found_o),
    .key_out_o    (key_out_o),
    .value_out_o  (value_out_o),
    .entry_count_o(entry_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Receiver: switch among always-ready, coin-flip and run-length stall
  // patterns, each held for a random stretch of cycles.
  int   rx_mode  = 0;
  int   rx_left  = 0;
  int   rx_run   = 0;
  logic rx_level = 1'b0;

  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(20, 200);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 1) == 1);
      default: begin
        if (rx_run == 0) begin
          rx_level = ~rx_level;
          rx_run   = $urandom_range(1, 8);
        end
        rx_run--;
        out_ready_i <= rx_level;
      end
    endcase
  end

  // Monitor: sample both channels on the pre-edge values, feed the shadow
  // table, check replies and count cycles with no transfer for the watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        sb.note_request(sat_pkg::kind_e'(kind_i), key_i, value_i, position_i);
      end
      if (out_valid_o && out_ready_i) begin
        sb.check_reply(status_o, found_o, key_out_o, value_out_o, entry_count_o);
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("FAIL small_associative_table_unit");
        $finish;
      end
    end
  end

  // Present one item, hold it until taken, then pace the sender: bursts of
  // random length, mostly followed by a random gap, sometimes back to back.
  // Called and returns at a rising edge.
  task automatic issue(sat_pkg::kind_e kind, logic [31:0] key, logic [31:0] value,
                       logic [3:0] position);
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    key_i      <= key;
    value_i    <= value;
    position_i <= position;
    // Ready is settled by the falling edge; inputs only move at rising edges.
    forever begin
      @(negedge clk_i);
      if (in_ready_o) break;
    end
    @(posedge clk_i);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  endtask

  // Mostly keys from a small pool so that hits, fills and removes happen.
  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, PoolSize - 1)];
    return $urandom;
  endfunction

  // Bias reads toward live slots, with some beyond the count.
  function automatic logic [3:0] pick_position();
    if (sb.fill > 0 && $urandom_range(0, 99) < 70) return 4'($urandom_range(0, sb.fill - 1));
    return 4'($urandom_range(0, 15));
  endfunction

  initial begin
    int             mode;
    int             roll;
    sat_pkg::kind_e kind;

    sb = new();
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table misses, key and value extremes, overwrite,
    // fill to capacity, put into a full table, remove of the last slot and
    // remove that moves the last entry down.
    issue(sat_pkg::KIND_LOOKUP, 32'h0000_0000, 32'h0, 4'd0);
    issue(sat_pkg::KIND_REMOVE, 32'h0000_0000, 32'h0, 4'd0);
    issue(sat_pkg::KIND_READ,   32'h0000_0000, 32'h0, 4'd0);
    issue(sat_pkg::KIND_PUT,    32'h0000_0000, 32'hFFFF_FFFF, 4'd15);
    issue(sat_pkg::KIND_PUT,    32'hFFFF_FFFF, 32'h0000_0000, 4'd0);
    issue(sat_pkg::KIND_PUT,    32'h0000_0000, 32'h1234_5678, 4'd0);
    issue(sat_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd0);
    issue(sat_pkg::KIND_READ,   32'h5555_5555, 32'hAAAA_AAAA, 4'd1);
    issue(sat_pkg::KIND_READ,   32'h0000_0000, 32'h0, 4'd15);
    for (int i = 0; i < Cap - 2; i++) begin
      issue(sat_pkg::KIND_PUT, 32'h8000_0000 | 32'(i), 32'hC000_0000 | 32'(i), 4'(i));
    end
    issue(sat_pkg::KIND_PUT,    32'h7FFF_FFFF, 32'h0BAD_0BAD, 4'd0);
    issue(sat_pkg::KIND_PUT,    32'hFFFF_FFFF, 32'hDEAD_BEEF, 4'd0);
    issue(sat_pkg::KIND_READ,   32'h0000_0000, 32'h0, 4'd15);
    issue(sat_pkg::KIND_REMOVE, 32'h8000_0000 | 32'(Cap - 3), 32'h0, 4'd0);
    issue(sat_pkg::KIND_REMOVE, 32'h0000_0000, 32'h0, 4'd0);
    issue(sat_pkg::KIND_READ,   32'h0000_0000, 32'h0, 4'd0);

    // Random: phases that favor filling, draining or a balanced mix.
    mode = 0;
    for (int n = 0; n < RandomItems; n++) begin
      if (n % 100 == 0) mode = $urandom_range(0, 2);
      roll = $urandom_range(0, 99);
      case (mode)
        0:       kind = (roll < 55) ? sat_pkg::KIND_PUT :
                        (roll < 75) ? sat_pkg::KIND_LOOKUP :
                        (roll < 85) ? sat_pkg::KIND_REMOVE : sat_pkg::KIND_READ;
        1:       kind = (roll < 15) ? sat_pkg::KIND_PUT :
                        (roll < 35) ? sat_pkg::KIND_LOOKUP :
                        (roll < 85) ? sat_pkg::KIND_REMOVE : sat_pkg::KIND_READ;
        default: kind = sat_pkg::kind_e'(roll % 4);
      endcase
      issue(kind, pick_key(), $urandom, pick_position());
    end

    // Drain: hold valid low, wait out every owed reply, then settle.
    in_valid_i <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (sb.n_errors == 0) begin
      $display("PASS small_associative_table_unit");
    end else begin
      $display("FAIL small_associative_table_unit");
    end
    $finish;
  end

endmodule
